// ----- rtl/core/cube_face_stepper_sequencer_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the cube face stepper sequencer
// Concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CUBE_FACE_STEPPER_SEQUENCER_ASSERT_SVH
`define CUBE_FACE_STEPPER_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
// condition holds in the same cycle
`define CFSS_ASSERT_NOW(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("cfss check failed: now");
// antecedent implies consequent in the next cycle
`define CFSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfss check failed: next");
`else
`define CFSS_ASSERT_NOW(label, clk, rst, cond)
`define CFSS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/cfss_pkg.sv -----
// ----------------------------------------------------------------------------
// cfss_pkg
// Move letter decode and half-step coil patterns for the cube face sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfss_pkg;

  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_L = 8'h6C;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_D = 8'h64;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_B = 8'h62;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  localparam logic [6:0] STEPS_R_CW    = 7'd110;
  localparam logic [6:0] STEPS_R_CCW   = 7'd100;
  localparam logic [6:0] STEPS_DEFAULT = 7'd102;
  localparam logic [6:0] STEPS_F_CCW   = 7'd104;
  localparam logic [6:0] STEPS_B_CW    = 7'd106;

  localparam logic [2:0] FACE_R = 3'd0;
  localparam logic [2:0] FACE_L = 3'd1;
  localparam logic [2:0] FACE_U = 3'd2;
  localparam logic [2:0] FACE_D = 3'd3;
  localparam logic [2:0] FACE_F = 3'd4;
  localparam logic [2:0] FACE_B = 3'd5;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  localparam logic CFG_STEP_INTERVAL = 1'b0;
  localparam logic CFG_GAP_INTERVAL  = 1'b1;

  localparam logic [15:0] INTERVAL_RESET = 16'd1000;

  typedef struct packed {
    logic       known;
    logic [2:0] face;
    logic       rev;
    logic [6:0] steps;
  } move_t;

  function automatic move_t decode_move(input logic [7:0] code);
    move_t      m;
    logic [7:0] lower;
    logic       upper;
    logic       alpha;
    m     = '0;
    lower = code | CASE_BIT;
    upper = (code >= CH_UPPER_A) && (code <= CH_UPPER_Z);
    alpha = upper || ((code >= CH_LOWER_A) && (code <= CH_LOWER_Z));
    m.rev = upper;
    if (alpha) begin
      m.known = 1'b1;
      case (lower)
        CH_R: begin
          m.face  = FACE_R;
          m.steps = upper ? STEPS_R_CCW : STEPS_R_CW;
        end
        CH_L: begin
          m.face  = FACE_L;
          m.steps = STEPS_DEFAULT;
        end
        CH_U: begin
          m.face  = FACE_U;
          m.steps = STEPS_DEFAULT;
        end
        CH_D: begin
          m.face  = FACE_D;
          m.steps = STEPS_DEFAULT;
        end
        CH_F: begin
          m.face  = FACE_F;
          m.steps = upper ? STEPS_F_CCW : STEPS_DEFAULT;
        end
        CH_B: begin
          m.face  = FACE_B;
          m.steps = upper ? STEPS_DEFAULT : STEPS_B_CW;
        end
        default: begin
          m.known = 1'b0;
        end
      endcase
    end
    return m;
  endfunction

  function automatic logic [3:0] half_step(input logic [2:0] idx);
    logic [3:0] p;
    case (idx)
      3'd0:    p = 4'h1;
      3'd1:    p = 4'h5;
      3'd2:    p = 4'h4;
      3'd3:    p = 4'h6;
      3'd4:    p = 4'h2;
      3'd5:    p = 4'hA;
      3'd6:    p = 4'h8;
      default: p = 4'h9;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/core/cube_face_stepper_sequencer.sv -----
// ----------------------------------------------------------------------------
// cube_face_stepper_sequencer
// Half-step sequencer for six four-coil face motors driven by move letters.
//
//   channel   dir  handshake            payload
//   s_axis    in   tvalid/tready        tuser: operation, tdata: move_code
//   m_axis    out  tvalid/tready        tdata: coil_lines, busy, rejected, done
//   cfg       in   cfg_we               cfg_index, cfg_data
//
// One word in, one word out; a word is taken every cycle while the output
// register is empty or being drained, and its result is registered.
// The state update and the result register sit behind one level of logic.
// rst clears the sequencer state, both intervals to 1000 and the output valid.
// A stalled m_axis holds its word and stalls s_axis only while it is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "cube_face_stepper_sequencer_assert.svh"

module cube_face_stepper_sequencer
  import cfss_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] move_code
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [23:0] coil_lines, [24] busy_res,
                                      // [25] rejected, [26] move_done
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_STEP = 2'd1;
  localparam logic [1:0] PH_GAP  = 2'd2;

  localparam int LW = ((TIMER_BITS > 16) ? TIMER_BITS : 16) + 1;
  localparam logic [LW-1:0] TIMER_MAX = {{(LW-TIMER_BITS){1'b0}}, {TIMER_BITS{1'b1}}};
  localparam logic [LW-1:0] LIM_ONE   = {{(LW-1){1'b0}}, 1'b1};

  logic [15:0]           step_interval;
  logic [15:0]           gap_interval;
  logic [1:0]            run_phase;
  logic [2:0]            active_face;
  logic                  turn_reverse;
  logic [6:0]            steps_left;
  logic [6:0]            table_index;
  logic [TIMER_BITS-1:0] tick_count;

  logic [1:0]            run_phase_next;
  logic [2:0]            active_face_next;
  logic                  turn_reverse_next;
  logic [6:0]            steps_left_next;
  logic [6:0]            table_index_next;
  logic [TIMER_BITS-1:0] tick_count_next;
  logic                  rejected_next;
  logic                  done_next;
  logic [23:0]           coils_next;

  logic [LW-1:0] step_floor;
  logic [LW-1:0] step_lim;
  logic [LW-1:0] gap_ext;
  logic [LW-1:0] gap_lim;
  logic [LW-1:0] tick_inc;
  move_t         mv;
  logic          accept;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_interval <= INTERVAL_RESET;
      gap_interval  <= INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_INTERVAL: step_interval <= cfg_data;
        CFG_GAP_INTERVAL:  gap_interval  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    step_floor = (step_interval == 16'd0) ? LIM_ONE : LW'(step_interval);
    step_lim   = (step_floor > TIMER_MAX) ? TIMER_MAX : step_floor;
    gap_ext    = LW'(gap_interval);
    gap_lim    = (gap_ext > TIMER_MAX) ? TIMER_MAX : gap_ext;
    tick_inc   = LW'(tick_count) + LIM_ONE;
    mv         = decode_move(s_axis_tdata);
  end

  always_comb begin
    run_phase_next    = run_phase;
    active_face_next  = active_face;
    turn_reverse_next = turn_reverse;
    steps_left_next   = steps_left;
    table_index_next  = table_index;
    tick_count_next   = tick_count;
    rejected_next     = 1'b0;
    done_next         = 1'b0;
    if (s_axis_tuser == OP_MOVE) begin
      if (run_phase != PH_IDLE) begin
        rejected_next = 1'b1;
      end else if (!mv.known) begin
        tick_count_next = '0;
        steps_left_next = '0;
        if (gap_interval == 16'd0) begin
          done_next = 1'b1;
        end else begin
          run_phase_next = PH_GAP;
        end
      end else begin
        active_face_next  = mv.face;
        turn_reverse_next = mv.rev;
        steps_left_next   = mv.steps;
        table_index_next  = mv.rev ? mv.steps : 7'd0;
        tick_count_next   = '0;
        run_phase_next    = PH_STEP;
      end
    end else begin
      unique case (run_phase)
        PH_IDLE: ;
        PH_STEP: begin
          if (tick_inc >= step_lim) begin
            tick_count_next  = '0;
            steps_left_next  = (steps_left != 7'd0) ? steps_left - 7'd1 : 7'd0;
            table_index_next = turn_reverse ? table_index - 7'd1 : table_index + 7'd1;
            if (steps_left_next == 7'd0) begin
              if (gap_interval == 16'd0) begin
                run_phase_next = PH_IDLE;
                done_next      = 1'b1;
              end else begin
                run_phase_next = PH_GAP;
              end
            end
          end else begin
            tick_count_next = tick_inc[TIMER_BITS-1:0];
          end
        end
        PH_GAP: begin
          if (tick_inc >= gap_lim) begin
            tick_count_next = '0;
            run_phase_next  = PH_IDLE;
            done_next       = 1'b1;
          end else begin
            tick_count_next = tick_inc[TIMER_BITS-1:0];
          end
        end
        default: begin
          run_phase_next = PH_IDLE;
        end
      endcase
    end
    coils_next = (run_phase_next == PH_STEP)
               ? ({20'd0, half_step(table_index_next[2:0])} << {active_face_next, 2'b00})
               : 24'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_phase     <= PH_IDLE;
      active_face   <= '0;
      turn_reverse  <= 1'b0;
      steps_left    <= '0;
      table_index   <= '0;
      tick_count    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        run_phase    <= run_phase_next;
        active_face  <= active_face_next;
        turn_reverse <= turn_reverse_next;
        steps_left   <= steps_left_next;
        table_index  <= table_index_next;
        tick_count   <= tick_count_next;
      end
      if (accept) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {5'd0, done_next, rejected_next,
                       (run_phase_next != PH_IDLE), coils_next};
    end
  end

  `CFSS_ASSERT_NOW(a_coils_only_busy, clk, rst,
    !m_axis_tvalid || m_axis_tdata[23:0] == 24'd0 || m_axis_tdata[24])
  `CFSS_ASSERT_NOW(a_reject_not_done, clk, rst,
    !m_axis_tvalid || !(m_axis_tdata[25] && m_axis_tdata[26]))
  `CFSS_ASSERT_NOW(a_reject_busy, clk, rst,
    !m_axis_tvalid || !m_axis_tdata[25] || m_axis_tdata[24])
  `CFSS_ASSERT_NOW(a_step_has_steps, clk, rst,
    run_phase != PH_STEP || steps_left != 7'd0)
  `CFSS_ASSERT_NEXT(a_idle_timer_clear, clk, rst,
    1'b1, run_phase != PH_IDLE || tick_count == '0)

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// cube_face_stepper_sequencer testbench
// Sends tick and move words over the slave stream and checks every output
// word against a cycle-free model of the six face motors, including coil
// patterns, busy, rejection and move completion. Pacing on both streams
// varies in three stages; the intervals run through several values,
// zero and the counter maximum among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import cfss_pkg::*;

  localparam int CYCLE_LIMIT = 20000;

  localparam logic [3:0] COIL_PATTERN [8] = '{
    4'h1, 4'h5, 4'h4, 4'h6, 4'h2, 4'hA, 4'h8, 4'h9
  };

  typedef enum logic [1:0] {
    MOTOR_IDLE,
    MOTOR_STEP,
    MOTOR_PAUSE
  } motor_phase_t;

  typedef struct packed {
    logic        move_done;
    logic        rejected;
    logic        busy;
    logic [23:0] coils;
  } coil_word_t;

  class motor_scoreboard_t;
    logic [15:0]  hold_ticks;
    logic [15:0]  pause_ticks;
    motor_phase_t phase;
    logic [2:0]   face;
    logic         reverse;
    logic [6:0]   steps_left;
    logic [6:0]   index;
    logic [15:0]  ticks;
    coil_word_t   pending[$];
    int           errors;

    function new();
      hold_ticks  = INTERVAL_RESET;
      pause_ticks = INTERVAL_RESET;
      phase       = MOTOR_IDLE;
      face        = '0;
      reverse     = 1'b0;
      steps_left  = '0;
      index       = '0;
      ticks       = '0;
      errors      = 0;
    endfunction

    function void write_reg(input logic idx, input logic [15:0] value);
      if (idx == CFG_STEP_INTERVAL) begin
        hold_ticks = value;
      end else begin
        pause_ticks = value;
      end
    endfunction

    function bit start_pause();
      ticks      = '0;
      steps_left = '0;
      if (pause_ticks == 16'd0) begin
        phase = MOTOR_IDLE;
        return 1'b1;
      end
      phase = MOTOR_PAUSE;
      return 1'b0;
    endfunction

    function void take_word(input logic op, input logic [7:0] code);
      coil_word_t  w;
      logic [16:0] advanced;
      logic [15:0] limit;
      logic [7:0]  lower;
      logic        upper;
      logic        alpha;
      logic [6:0]  count;
      logic [2:0]  new_face;
      w = '0;
      if (op == OP_MOVE) begin
        if (phase != MOTOR_IDLE) begin
          w.rejected = 1'b1;
        end else begin
          upper    = (code >= CH_UPPER_A) && (code <= CH_UPPER_Z);
          alpha    = upper || ((code >= CH_LOWER_A) && (code <= CH_LOWER_Z));
          lower    = code | CASE_BIT;
          count    = '0;
          new_face = FACE_R;
          if (alpha) begin
            case (lower)
              CH_R: begin
                new_face = FACE_R;
                count    = upper ? STEPS_R_CCW : STEPS_R_CW;
              end
              CH_L: begin
                new_face = FACE_L;
                count    = STEPS_DEFAULT;
              end
              CH_U: begin
                new_face = FACE_U;
                count    = STEPS_DEFAULT;
              end
              CH_D: begin
                new_face = FACE_D;
                count    = STEPS_DEFAULT;
              end
              CH_F: begin
                new_face = FACE_F;
                count    = upper ? STEPS_F_CCW : STEPS_DEFAULT;
              end
              CH_B: begin
                new_face = FACE_B;
                count    = upper ? STEPS_DEFAULT : STEPS_B_CW;
              end
              default: begin
                count = '0;
              end
            endcase
          end
          if (count == 7'd0) begin
            if (start_pause()) w.move_done = 1'b1;
          end else begin
            face       = new_face;
            reverse    = upper;
            steps_left = count;
            index      = upper ? count : 7'd0;
            ticks      = '0;
            phase      = MOTOR_STEP;
          end
        end
      end else if (phase == MOTOR_STEP) begin
        limit    = (hold_ticks == 16'd0) ? 16'd1 : hold_ticks;
        advanced = {1'b0, ticks} + 17'd1;
        if (advanced >= {1'b0, limit}) begin
          ticks = '0;
          if (steps_left != 7'd0) steps_left = steps_left - 7'd1;
          index = reverse ? index - 7'd1 : index + 7'd1;
          if (steps_left == 7'd0 && start_pause()) w.move_done = 1'b1;
        end else begin
          ticks = advanced[15:0];
        end
      end else if (phase == MOTOR_PAUSE) begin
        advanced = {1'b0, ticks} + 17'd1;
        if (advanced >= {1'b0, pause_ticks}) begin
          ticks       = '0;
          phase       = MOTOR_IDLE;
          w.move_done = 1'b1;
        end else begin
          ticks = advanced[15:0];
        end
      end
      if (phase == MOTOR_STEP) begin
        w.coils = 24'(COIL_PATTERN[index[2:0]]) << (4 * face);
      end
      w.busy = (phase != MOTOR_IDLE);
      pending.push_back(w);
    endfunction

    function void check_word(input logic [31:0] data);
      coil_word_t got;
      coil_word_t want;
      got = data[26:0];
      if (pending.size() == 0) begin
        $error("output word %h with nothing expected", data);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.coils !== want.coils) begin
        $error("coil_lines expected %h got %h", want.coils, got.coils);
        errors++;
      end
      if (got.busy !== want.busy) begin
        $error("busy_res expected %b got %b", want.busy, got.busy);
        errors++;
      end
      if (got.rejected !== want.rejected) begin
        $error("rejected expected %b got %b", want.rejected, got.rejected);
        errors++;
      end
      if (got.move_done !== want.move_done) begin
        $error("move_done expected %b got %b", want.move_done, got.move_done);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] move_code
  logic        s_axis_tuser;   // [0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [23:0] coil_lines, [24] busy_res,
                               // [25] rejected, [26] move_done
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  motor_scoreboard_t tracker;
  int                src_idle;
  int                sink_idle;
  int                cycles = 0;

  cube_face_stepper_sequencer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      tracker.check_word(m_axis_tdata);
    end
    m_axis_tready <= ($urandom_range(99) >= sink_idle);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_word(input logic op, input logic [7:0] code);
    int pause;
    pause = 0;
    while ($urandom_range(99) < src_idle) pause++;
    if (pause > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= code;
    @(posedge clk);
    while (s_axis_tready !== 1'b1) @(posedge clk);
    tracker.take_word(op, code);
  endtask

  // tick until the move and its pause are over, with stray commands
  task automatic finish_motion();
    while (tracker.phase != MOTOR_IDLE) begin
      if ($urandom_range(99) < 4) begin
        send_word(OP_MOVE, 8'($urandom_range(255)));
      end else begin
        send_word(OP_TICK, 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic run_move(input logic [7:0] code);
    send_word(OP_MOVE, code);
    finish_motion();
  endtask

  task automatic write_interval(input logic idx, input logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.write_reg(idx, value);
  endtask

  task automatic random_move();
    logic [7:0] face_letters [6];
    logic [7:0] code;
    face_letters = '{CH_R, CH_L, CH_U, CH_D, CH_F, CH_B};
    if ($urandom_range(99) < 85) begin
      code = face_letters[$urandom_range(5)];
      if ($urandom_range(1)) code = code & ~CASE_BIT;
    end else begin
      code = 8'($urandom_range(255));
    end
    run_move(code);
  endtask

  initial begin
    logic [7:0] odd_codes [8];
    odd_codes     = '{8'h00, 8'hFF, CH_UPPER_A - 8'd1, CH_UPPER_Z + 8'd1,
                      CH_LOWER_A - 8'd1, CH_LOWER_Z + 8'd1, CH_UPPER_Z, CH_LOWER_A};
    tracker       = new();
    clk           = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = OP_TICK;
    s_axis_tdata  = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_STEP_INTERVAL;
    cfg_data      = '0;
    src_idle      = 28;
    sink_idle     = 59;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // idle ticks, then an unknown letter that waits out part of the reset pause
    send_word(OP_TICK, 8'h00);
    send_word(OP_TICK, 8'hFF);
    send_word(OP_MOVE, 8'h00);
    repeat (4) send_word(OP_TICK, 8'h00);
    write_interval(CFG_GAP_INTERVAL, 16'd0);
    finish_motion();

    write_interval(CFG_STEP_INTERVAL, 16'd0);
    foreach (odd_codes[i]) run_move(odd_codes[i]);
    send_word(OP_MOVE, CH_R & ~CASE_BIT);
    send_word(OP_MOVE, CH_R);
    finish_motion();
    write_interval(CFG_GAP_INTERVAL, 16'd2);
    run_move(CH_B);

    src_idle  = 59;
    sink_idle = 28;
    write_interval(CFG_STEP_INTERVAL, 16'd1);
    write_interval(CFG_GAP_INTERVAL, 16'd1);
    run_move(CH_F & ~CASE_BIT);
    random_move();

    // counter maximum, shortened partway through the move
    src_idle  = 0;
    sink_idle = 0;
    write_interval(CFG_STEP_INTERVAL, 16'hFFFF);
    write_interval(CFG_GAP_INTERVAL, 16'hFFFF);
    send_word(OP_TICK, 8'h5A);
    send_word(OP_MOVE, CH_U);
    repeat (3) send_word(OP_TICK, 8'h00);
    write_interval(CFG_STEP_INTERVAL, 16'd1);
    write_interval(CFG_GAP_INTERVAL, 16'd3);
    finish_motion();

    s_axis_tvalid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/cfss_pkg.sv
rtl/core/cube_face_stepper_sequencer.sv
tb/sv/testbench.sv
